[hw/rtl/cpm_pkg.sv]
// Shared types, register map and field constants for the clock and power manager
// register window. Used by cpm_named_regs and clock_power_manager_regs.
package cpm_pkg;

    localparam int WINDOW_WORDS_DEF = 1024;
    localparam int WORD_IDX_W       = 10;
    localparam int OFFSET_W         = 12;
    localparam int SIZE_W           = 3;
    localparam int DATA_W           = 32;
    localparam int GATE_W           = 16;
    localparam int S_TDATA_W        = 48;
    localparam int M_TDATA_W        = 56;

    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } cmd_t;

    localparam logic [SIZE_W-1:0] SIZE_BYTE = 3'd1;
    localparam logic [SIZE_W-1:0] SIZE_HALF = 3'd2;
    localparam logic [SIZE_W-1:0] SIZE_WORD = 3'd4;

    localparam logic [WORD_IDX_W-1:0] W_CORE   = 10'd0;
    localparam logic [WORD_IDX_W-1:0] W_LOWP   = 10'd1;
    localparam logic [WORD_IDX_W-1:0] W_PLL    = 10'd4;
    localparam logic [WORD_IDX_W-1:0] W_GATE   = 10'd8;
    localparam logic [WORD_IDX_W-1:0] W_SLEEP  = 10'd9;
    localparam logic [WORD_IDX_W-1:0] W_AUDIO  = 10'd24;
    localparam logic [WORD_IDX_W-1:0] W_PIXEL  = 10'd25;
    localparam logic [WORD_IDX_W-1:0] W_CARD   = 10'd26;
    localparam logic [WORD_IDX_W-1:0] W_USB    = 10'd27;
    localparam logic [WORD_IDX_W-1:0] W_SERIAL = 10'd29;

    localparam logic [DATA_W-1:0] PLL_RW     = 32'hffff03ff;
    localparam logic [DATA_W-1:0] PLL_EN     = 32'h00000100;
    localparam logic [DATA_W-1:0] PLL_STABLE = 32'h00000400;
    localparam logic [DATA_W-1:0] SLEEP_RW   = 32'h0000ffd0;
    localparam logic [DATA_W-1:0] PIXEL_RW   = 32'h800007ff;
    localparam logic [DATA_W-1:0] SERIAL_RW  = 32'h8000000f;
    localparam logic [DATA_W-1:0] GATE_WAKE  = 32'h00004a80;
    localparam logic [DATA_W-1:0] SLEEP_WAKE = 32'h00000080;
    localparam logic [DATA_W-1:0] BYTE_MASK  = 32'h000000ff;
    localparam logic [DATA_W-1:0] HALF_MASK  = 32'h0000ffff;

    localparam logic [DATA_W-1:0] CORE_RST   = 32'h00000008;
    localparam logic [7:0]        LOWP_RST   = 8'hf8;
    localparam logic [DATA_W-1:0] PLL_RST    = 32'h28080011;
    localparam logic [15:0]       SLEEP_RST  = 16'h1500;
    localparam logic [3:0]        DIV_RST    = 4'h4;

    typedef struct packed {
        logic named;
        logic word_only;
    } decode_t;

    typedef struct packed {
        logic [GATE_W-1:0] gate_wake;
        logic              sleep_wake;
    } wake_t;

endpackage

[hw/rtl/cpm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/cpm_named_regs.sv]
// Named control registers of the window: decode, writable masks, PLL stable
// forcing and wake-source status. Depends on cpm_pkg.
module cpm_named_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [cpm_pkg::WORD_IDX_W-1:0]      word,
    input  logic                                wr_en,
    input  logic [cpm_pkg::DATA_W-1:0]          wr_value,
    output logic [cpm_pkg::DATA_W-1:0]          rd_word,
    output cpm_pkg::decode_t                    dec,
    output cpm_pkg::wake_t                      wake
);

    logic [31:0] core_reg;
    logic [7:0]  lowp_reg;
    logic [31:0] pll_reg;
    logic [15:0] gate_reg;
    logic [15:0] sleep_reg;
    logic [8:0]  audio_reg;
    logic [31:0] pixel_reg;
    logic [4:0]  card_reg;
    logic [3:0]  usb_reg;
    logic [31:0] serial_reg;

    logic [31:0] pll_next;
    logic [15:0] gate_next;
    logic [15:0] sleep_next;

    always_comb begin
        rd_word       = '0;
        dec.named     = 1'b1;
        dec.word_only = 1'b0;
        unique case (word)
            cpm_pkg::W_CORE: begin
                rd_word       = core_reg;
                dec.word_only = 1'b1;
            end
            cpm_pkg::W_LOWP:  rd_word = {24'd0, lowp_reg};
            cpm_pkg::W_PLL: begin
                rd_word       = pll_reg;
                dec.word_only = 1'b1;
            end
            cpm_pkg::W_GATE:  rd_word = {16'd0, gate_reg};
            cpm_pkg::W_SLEEP: rd_word = {16'd0, sleep_reg};
            cpm_pkg::W_AUDIO: begin
                rd_word       = {23'd0, audio_reg};
                dec.word_only = 1'b1;
            end
            cpm_pkg::W_PIXEL: begin
                rd_word       = pixel_reg;
                dec.word_only = 1'b1;
            end
            cpm_pkg::W_CARD: begin
                rd_word       = {27'd0, card_reg};
                dec.word_only = 1'b1;
            end
            cpm_pkg::W_USB: begin
                rd_word       = {28'd0, usb_reg};
                dec.word_only = 1'b1;
            end
            cpm_pkg::W_SERIAL: begin
                rd_word       = serial_reg;
                dec.word_only = 1'b1;
            end
            default: dec.named = 1'b0;
        endcase
    end

    always_comb begin
        pll_next = wr_value & cpm_pkg::PLL_RW;
        if ((pll_next & cpm_pkg::PLL_EN) != '0) begin
            pll_next = pll_next | cpm_pkg::PLL_STABLE;
        end
        gate_next  = (wr_en && word == cpm_pkg::W_GATE) ? wr_value[15:0] : gate_reg;
        sleep_next = (wr_en && word == cpm_pkg::W_SLEEP)
                   ? 16'(wr_value & cpm_pkg::SLEEP_RW) : sleep_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            core_reg   <= cpm_pkg::CORE_RST;
            lowp_reg   <= cpm_pkg::LOWP_RST;
            pll_reg    <= cpm_pkg::PLL_RST;
            gate_reg   <= '0;
            sleep_reg  <= cpm_pkg::SLEEP_RST;
            audio_reg  <= 9'(cpm_pkg::DIV_RST);
            pixel_reg  <= 32'(cpm_pkg::DIV_RST);
            card_reg   <= 5'(cpm_pkg::DIV_RST);
            usb_reg    <= cpm_pkg::DIV_RST;
            serial_reg <= 32'(cpm_pkg::DIV_RST);
        end else begin
            gate_reg  <= gate_next;
            sleep_reg <= sleep_next;
            if (wr_en) begin
                unique case (word)
                    cpm_pkg::W_CORE:   core_reg   <= wr_value;
                    cpm_pkg::W_LOWP:   lowp_reg   <= wr_value[7:0];
                    cpm_pkg::W_PLL:    pll_reg    <= pll_next;
                    cpm_pkg::W_AUDIO:  audio_reg  <= wr_value[8:0];
                    cpm_pkg::W_PIXEL:  pixel_reg  <= wr_value & cpm_pkg::PIXEL_RW;
                    cpm_pkg::W_CARD:   card_reg   <= wr_value[4:0];
                    cpm_pkg::W_USB:    usb_reg    <= wr_value[3:0];
                    cpm_pkg::W_SERIAL: serial_reg <= wr_value & cpm_pkg::SERIAL_RW;
                    default: ;
                endcase
            end
        end
    end

    assign wake.gate_wake  = gate_next & 16'(cpm_pkg::GATE_WAKE);
    assign wake.sleep_wake = (32'(sleep_next) & cpm_pkg::SLEEP_WAKE) != '0;

endmodule

[hw/rtl/clock_power_manager_regs.sv]
// Top level of the clock and power manager register window: access stage,
// scratch storage, result register. Depends on cpm_pkg, cpm_ram, cpm_named_regs.
//
//   channel  | direction | words carried
//   s_       | in        | one bus access (read or write) per word
//   m_       | out       | one result per access, in order
//
// One access per cycle sustained while m_tready is high; m_tvalid rises after its
// word is taken: the input register holds the access and the result register
// then loads from it when the m_ side advances. Scratch storage is a RAM
// read on accept, merged and written back in the access stage, with the last
// write forwarded to a following access of the same word.
// After reset a clearing pass zeroes every RAM word; s_tready stays low
// meanwhile. A stalled m_ side holds the access stage; the input register
// takes a word only while empty, so one access at most waits behind the result.
module clock_power_manager_regs #(
    parameter int WINDOW_WORDS = cpm_pkg::WINDOW_WORDS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [11:0] byte_offset, [14:12] access_size, [46:15] write_data, [47] zero
    input  logic [cpm_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] cmd
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] read_data, [32] change_notify, [48:33] gate_wake_bits,
    // [49] sleep_wake_bit, [50] wake_enabled, [55:51] zero
    output logic [cpm_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(WINDOW_WORDS);

    logic                              clr_active_reg;
    logic [AW-1:0]                     clr_cnt_reg;

    logic                              stg_valid_reg;
    cpm_pkg::cmd_t                     stg_cmd_reg;
    logic [cpm_pkg::OFFSET_W-1:0]      stg_off_reg;
    logic [cpm_pkg::SIZE_W-1:0]        stg_size_reg;
    logic [cpm_pkg::DATA_W-1:0]        stg_data_reg;

    logic                              fwd_valid_reg;
    logic [cpm_pkg::WORD_IDX_W-1:0]    fwd_word_reg;
    logic [cpm_pkg::DATA_W-1:0]        fwd_data_reg;

    logic                              res_valid_reg;
    logic [cpm_pkg::M_TDATA_W-1:0]     res_data_reg;
    logic [cpm_pkg::M_TDATA_W-1:0]     res_data_next;

    logic                              advance;
    logic                              accept;
    logic [cpm_pkg::WORD_IDX_W-1:0]    in_word;
    logic [cpm_pkg::WORD_IDX_W-1:0]    word;
    logic [1:0]                        lane;
    logic [4:0]                        rd_shift;
    logic [4:0]                        wr_shift;
    logic                              in_window;
    logic [cpm_pkg::DATA_W-1:0]        ram_rdata;
    logic [cpm_pkg::DATA_W-1:0]        named_rd;
    cpm_pkg::decode_t                  dec;
    cpm_pkg::wake_t                    wake;
    logic [cpm_pkg::DATA_W-1:0]        old_word;
    logic [cpm_pkg::DATA_W-1:0]        lanes;
    logic [cpm_pkg::DATA_W-1:0]        merged;
    logic [cpm_pkg::DATA_W-1:0]        rd_value;
    logic                              is_write;
    logic                              do_write;
    logic                              named_we;
    logic                              stg_ram_we;
    logic                              notify;
    logic                              ram_we;
    logic [AW-1:0]                     ram_waddr;
    logic [cpm_pkg::DATA_W-1:0]        ram_wdata;

    assign advance  = !res_valid_reg || m_tready;
    assign s_tready = !clr_active_reg && (!stg_valid_reg || advance);
    assign accept   = s_tvalid && s_tready;
    assign in_word  = s_tdata[11:2];

    assign word      = stg_off_reg[11:2];
    assign lane      = stg_off_reg[1:0];
    assign rd_shift  = {lane, 3'b000};
    assign in_window = 32'(word) < 32'(WINDOW_WORDS);
    assign is_write  = stg_cmd_reg == cpm_pkg::CMD_WRITE;

    cpm_ram #(
        .WIDTH (cpm_pkg::DATA_W),
        .DEPTH (WINDOW_WORDS)
    ) u_scratch (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (in_word[AW-1:0]),
        .rdata (ram_rdata)
    );

    cpm_named_regs u_named (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .word     (word),
        .wr_en    (named_we),
        .wr_value (merged),
        .rd_word  (named_rd),
        .dec      (dec),
        .wake     (wake)
    );

    always_comb begin
        if (dec.named) begin
            old_word = named_rd;
        end else if (!in_window) begin
            old_word = '0;
        end else if (fwd_valid_reg && fwd_word_reg == word) begin
            old_word = fwd_data_reg;
        end else begin
            old_word = ram_rdata;
        end

        wr_shift = rd_shift;
        case (stg_size_reg)
            cpm_pkg::SIZE_BYTE: lanes = cpm_pkg::BYTE_MASK << rd_shift;
            cpm_pkg::SIZE_HALF: lanes = cpm_pkg::HALF_MASK << rd_shift;
            default: begin
                lanes    = '1;
                wr_shift = '0;
            end
        endcase
        merged = (old_word & ~lanes) | ((stg_data_reg << wr_shift) & lanes);

        rd_value = old_word >> rd_shift;
        case (stg_size_reg)
            cpm_pkg::SIZE_BYTE: rd_value = rd_value & cpm_pkg::BYTE_MASK;
            cpm_pkg::SIZE_HALF: rd_value = rd_value & cpm_pkg::HALF_MASK;
            default: ;
        endcase
        if (is_write) begin
            rd_value = '0;
        end

        do_write   = stg_valid_reg && advance && is_write
                   && !(dec.word_only && (lane != 2'd0 || stg_size_reg != cpm_pkg::SIZE_WORD));
        named_we   = do_write && dec.named;
        stg_ram_we = do_write && !dec.named && in_window;
        notify     = is_write && (word == cpm_pkg::W_GATE || word == cpm_pkg::W_SLEEP);

        if (clr_active_reg) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = stg_ram_we;
            ram_waddr = word[AW-1:0];
            ram_wdata = merged;
        end

        res_data_next = {5'd0,
                         (wake.gate_wake != '0) || wake.sleep_wake,
                         wake.sleep_wake,
                         wake.gate_wake,
                         notify,
                         rd_value};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
            stg_valid_reg  <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            res_valid_reg  <= 1'b0;
        end else begin
            if (clr_active_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(WINDOW_WORDS - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (s_tready) begin
                stg_valid_reg <= s_tvalid;
            end
            if (stg_ram_we) begin
                fwd_valid_reg <= 1'b1;
            end
            if (advance) begin
                res_valid_reg <= stg_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stg_cmd_reg  <= cpm_pkg::cmd_t'(s_tuser);
            stg_off_reg  <= s_tdata[11:0];
            stg_size_reg <= s_tdata[14:12];
            stg_data_reg <= s_tdata[46:15];
        end
        if (stg_ram_we) begin
            fwd_word_reg <= word;
            fwd_data_reg <= merged;
        end
        if (advance && stg_valid_reg) begin
            res_data_reg <= res_data_next;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = res_data_reg;

    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !s_tready)
        else $error("word accepted during clearing pass");

    a_clear_after_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> clr_active_reg)
        else $error("clearing pass not running after reset");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        stg_valid_reg && !advance |=> stg_valid_reg && $stable(stg_off_reg))
        else $error("access stage lost its word while stalled");

    a_single_ram_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        !(clr_active_reg && stg_ram_we))
        else $error("stage write collides with clearing pass");

endmodule
